@@ sv/mrc_pkg.sv @@
// mrc_pkg: shared widths, codes and item types for the min/max rescale converter
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package mrc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int SAMPLE_W  = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int MODE_W    = 2;
  localparam int SCALE_W   = 48;
  localparam int SPLIT_W   = 24;
  localparam int QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MODE = 2'd2;

  // output modes
  localparam logic [MODE_W-1:0] MODE_BYTE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_S16   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_U16   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FIXED = 2'd3;

  // input func codes
  localparam logic FUNC_MEASURE = 1'b0;
  localparam logic FUNC_CONVERT = 1'b1;

  // queue command codes
  localparam logic OP_LATCH   = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  // integer output ranges
  localparam int BYTE_MAX = 255;
  localparam int S16_MIN  = -32768;
  localparam int S16_MAX  = 32767;
  localparam int U16_MAX  = 65535;

  typedef struct packed {
    logic                       op;
    logic signed [SAMPLE_W-1:0] a;     // sample, or running minimum
    logic signed [SAMPLE_W-1:0] b;     // running maximum
    logic                       last;
  } cmd_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] out_min;
    logic signed [CFG_W-1:0] out_max;
    logic [MODE_W-1:0]       out_mode;
  } cfg_t;

endpackage

`default_nettype wire

@@ sv/mrc_in_if.sv @@
// mrc_in_if: input sample channel, valid/ready with func, sample and pass_last
// depends on mrc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface mrc_in_if;
  import mrc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       func;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       pass_last;

  modport source (output valid, output func, output sample, output pass_last, input ready);
  modport sink (input valid, input func, input sample, input pass_last, output ready);
endinterface

`default_nettype wire

@@ sv/mrc_out_if.sv @@
// mrc_out_if: result channel, valid/ready with value and last
// depends on mrc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface mrc_out_if;
  import mrc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] value;
  logic                       last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

@@ sv/mrc_fifo.sv @@
// mrc_fifo: short flop queue of commands between front and back
// depends on mrc_pkg (cmd_t)
`timescale 1ns / 1ps
`default_nettype none

module mrc_fifo #(
  parameter int DEPTH = mrc_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mrc_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output mrc_pkg::cmd_t pop_data,
  output logic          empty
);
  import mrc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ sv/mrc_div.sv @@
// mrc_div: restoring divider on unsigned magnitudes, one quotient bit per cycle
// depends on mrc_pkg for default widths
`timescale 1ns / 1ps
`default_nettype none

module mrc_div #(
  parameter int NUM_W = mrc_pkg::SAMPLE_W + 1 + mrc_pkg::FRAC_BITS_DEF,
  parameter int DEN_W = mrc_pkg::SAMPLE_W + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r, den_r;
  logic [NUM_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DEN_W:0]   shifted, diff;
  logic             fits;

  assign shifted  = {rem_r, quo_r[NUM_W-1]};
  assign fits     = (shifted >= {1'b0, den_r});
  assign diff     = shifted - {1'b0, den_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

@@ sv/mrc_front.sv @@
// mrc_front: accepts samples, tracks running min/max, queues latch and convert commands
// depends on mrc_pkg, mrc_in_if
`timescale 1ns / 1ps
`default_nettype none

module mrc_front (
  input  logic          clk,
  input  logic          rst_n,
  mrc_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          q_push,
  output mrc_pkg::cmd_t q_data
);
  import mrc_pkg::*;

  logic signed [SAMPLE_W-1:0] min_r, max_r, min_nxt, max_nxt;
  logic                       restart_r;
  logic                       take, measure;

  assign in_ch.ready = !q_full;
  assign take        = in_ch.valid && !q_full;
  assign measure     = (in_ch.func == FUNC_MEASURE);

  always_comb begin
    if (restart_r) begin
      min_nxt = in_ch.sample;
      max_nxt = in_ch.sample;
    end else begin
      min_nxt = (in_ch.sample < min_r) ? in_ch.sample : min_r;
      max_nxt = (in_ch.sample > max_r) ? in_ch.sample : max_r;
    end
  end

  assign q_push      = take && (!measure || in_ch.pass_last);
  assign q_data.op   = measure ? OP_LATCH : OP_CONVERT;
  assign q_data.a    = measure ? min_nxt : in_ch.sample;
  assign q_data.b    = max_nxt;
  assign q_data.last = in_ch.pass_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r     <= '0;
      max_r     <= '0;
      restart_r <= 1'b1;
    end else if (take) begin
      if (measure) begin
        min_r     <= min_nxt;
        max_r     <= max_nxt;
        restart_r <= in_ch.pass_last;
      end else if (in_ch.pass_last) begin
        restart_r <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/mrc_back.sv @@
// mrc_back: sequencer for scale latch and sample conversion, shared multiplier,
// output register; depends on mrc_pkg, mrc_out_if, mrc_div
`timescale 1ns / 1ps
`default_nettype none

module mrc_back #(
  parameter int FRAC_BITS = mrc_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mrc_pkg::cfg_t cfg,
  input  logic          cmd_valid,
  input  mrc_pkg::cmd_t cmd,
  output logic          cmd_pop,
  mrc_out_if.source     out_ch
);
  import mrc_pkg::*;

  localparam int NUM_W  = SAMPLE_W + 1 + FRAC_BITS;
  localparam int DEN_W  = SAMPLE_W + 1;
  localparam int PROD_W = SAMPLE_W + SPLIT_W + 1;
  localparam int ACC_W  = SAMPLE_W + SCALE_W + 1;
  localparam int QX_W   = ((NUM_W > SCALE_W) ? NUM_W : SCALE_W) + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MLO  = 3'd2;
  localparam logic [2:0] ST_MHI  = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_OFS  = 3'd5;
  localparam logic [2:0] ST_SHF  = 3'd6;
  localparam logic [2:0] ST_SAT  = 3'd7;

  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_F  = 2'd1;
  localparam logic [1:0] SH_2F = 2'd2;

  localparam logic [DEN_W-1:0] DEN_ONE =
    {{(DEN_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [ACC_W-1:0] MASK_F  =
    {{(ACC_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
  localparam logic signed [ACC_W-1:0] MASK_2F =
    {{(ACC_W-2*FRAC_BITS){1'b0}}, {(2*FRAC_BITS){1'b1}}};
  localparam logic signed [QX_W-1:0] Q_MAX =
    {{(QX_W-SCALE_W+1){1'b0}}, {(SCALE_W-1){1'b1}}};
  localparam logic signed [QX_W-1:0] Q_MIN =
    {{(QX_W-SCALE_W+1){1'b1}}, {(SCALE_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] B48_MAX =
    {{(ACC_W-SCALE_W+1){1'b0}}, {(SCALE_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] B48_MIN =
    {{(ACC_W-SCALE_W+1){1'b1}}, {(SCALE_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] B32_MAX =
    {{(ACC_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] B32_MIN =
    {{(ACC_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

  logic [2:0]                 state_r, state_nxt;
  logic                       op_r, last_r, neg_r;
  logic [1:0]                 shsel_r;
  logic signed [SAMPLE_W-1:0] a_r;
  logic signed [SCALE_W-1:0]  scale_r, base_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       ov_r, olast_r;
  logic signed [SAMPLE_W-1:0] oval_r;

  logic                       scaled, mode_fixed, out_free, load_out;
  logic signed [DEN_W-1:0]    num, den;
  logic [DEN_W-1:0]           num_abs, den_use;
  logic [NUM_W-1:0]           div_dividend, div_q;
  logic                       div_start, div_done;
  logic signed [QX_W-1:0]     q_ext, q_sgn;
  logic signed [SCALE_W-1:0]  scale_new;
  logic [SPLIT_W:0]           mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [ACC_W-1:0]    acc_hi, acc_ofs, acc_shf, sum_f, sum_2f;
  logic signed [ACC_W-1:0]    sat_lo, sat_hi, sat_v;

  assign scaled     = (cfg.out_min != '0) || (cfg.out_max != '0);
  assign mode_fixed = (cfg.out_mode == MODE_FIXED);
  assign cmd_pop    = (state_r == ST_IDLE) && cmd_valid;
  assign out_free   = !ov_r || out_ch.ready;
  assign load_out   = (state_r == ST_SAT) && (op_r == OP_CONVERT) && out_free;

  // scale = (out_max - out_min) * 2^F / (max - min)
  assign num          = DEN_W'($signed(cfg.out_max)) - DEN_W'($signed(cfg.out_min));
  assign num_abs      = num[DEN_W-1] ? -num : num;
  assign den          = DEN_W'(cmd.b) - DEN_W'(cmd.a);
  assign den_use      = (den == '0) ? DEN_ONE : den;
  assign div_dividend = {num_abs, {FRAC_BITS{1'b0}}};
  assign div_start    = cmd_pop && (cmd.op == OP_LATCH);

  mrc_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (den_use),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q_ext = {{(QX_W-NUM_W){1'b0}}, div_q};
  assign q_sgn = neg_r ? -q_ext : q_ext;
  always_comb begin
    if (q_sgn > Q_MAX) begin
      scale_new = Q_MAX[SCALE_W-1:0];
    end else if (q_sgn < Q_MIN) begin
      scale_new = Q_MIN[SCALE_W-1:0];
    end else begin
      scale_new = q_sgn[SCALE_W-1:0];
    end
  end

  // 48-bit scale split in two halves through one 32x25 multiplier
  assign mul_b = (state_r == ST_MLO) ? {1'b0, scale_r[SPLIT_W-1:0]}
                                     : {scale_r[SCALE_W-1], scale_r[SCALE_W-1:SPLIT_W]};
  assign mul_p = a_r * $signed(mul_b);

  assign acc_hi  = acc_r + (ACC_W'(prod_r) <<< SPLIT_W);
  assign acc_ofs = (op_r == OP_LATCH)
                 ? (ACC_W'($signed(cfg.out_min)) <<< FRAC_BITS) - acc_r
                 : acc_r + (ACC_W'(base_r) <<< FRAC_BITS);

  // truncate toward zero
  assign sum_f  = acc_r + (acc_r[ACC_W-1] ? MASK_F : '0);
  assign sum_2f = acc_r + (acc_r[ACC_W-1] ? MASK_2F : '0);
  always_comb begin
    case (shsel_r)
      SH_F:    acc_shf = sum_f >>> FRAC_BITS;
      SH_2F:   acc_shf = sum_2f >>> (2 * FRAC_BITS);
      default: acc_shf = acc_r;
    endcase
  end

  always_comb begin
    if (op_r == OP_LATCH) begin
      sat_lo = B48_MIN;
      sat_hi = B48_MAX;
    end else begin
      unique case (cfg.out_mode)
        MODE_BYTE: begin
          sat_lo = '0;
          sat_hi = ACC_W'(BYTE_MAX);
        end
        MODE_S16: begin
          sat_lo = ACC_W'(S16_MIN);
          sat_hi = ACC_W'(S16_MAX);
        end
        MODE_U16: begin
          sat_lo = '0;
          sat_hi = ACC_W'(U16_MAX);
        end
        default: begin
          sat_lo = B32_MIN;
          sat_hi = B32_MAX;
        end
      endcase
    end
    if (acc_r < sat_lo) begin
      sat_v = sat_lo;
    end else if (acc_r > sat_hi) begin
      sat_v = sat_hi;
    end else begin
      sat_v = acc_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == OP_LATCH) begin
            state_nxt = ST_DIV;
          end else if (scaled) begin
            state_nxt = ST_MLO;
          end else begin
            state_nxt = ST_SHF;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_MLO;
        end
      end
      ST_MLO: state_nxt = ST_MHI;
      ST_MHI: state_nxt = ST_ACC;
      ST_ACC: state_nxt = ST_OFS;
      ST_OFS: state_nxt = ST_SHF;
      ST_SHF: state_nxt = ST_SAT;
      ST_SAT: begin
        if (op_r == OP_LATCH || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      scale_r <= '0;
      base_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
      if (state_r == ST_DIV && div_done) begin
        scale_r <= scale_new;
      end
      if (state_r == ST_SAT && op_r == OP_LATCH) begin
        base_r <= sat_v[SCALE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          op_r   <= cmd.op;
          a_r    <= cmd.a;
          last_r <= cmd.last;
          neg_r  <= num[DEN_W-1];
          acc_r  <= ACC_W'(cmd.a);
          if (cmd.op == OP_LATCH) begin
            shsel_r <= SH_F;
          end else if (scaled) begin
            shsel_r <= mode_fixed ? SH_F : SH_2F;
          end else begin
            shsel_r <= mode_fixed ? SH_0 : SH_F;
          end
        end
      end
      ST_MLO: prod_r <= mul_p;
      ST_MHI: begin
        acc_r  <= ACC_W'(prod_r);
        prod_r <= mul_p;
      end
      ST_ACC: acc_r <= acc_hi;
      ST_OFS: acc_r <= acc_ofs;
      ST_SHF: acc_r <= acc_shf;
      default: ;
    endcase
    if (load_out) begin
      oval_r  <= sat_v[SAMPLE_W-1:0];
      olast_r <= last_r;
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.value = oval_r;
  assign out_ch.last  = olast_r;

endmodule

`default_nettype wire

@@ sv/minmax_rescale_convert.sv @@
// minmax_rescale_convert: top level, configuration registers, front, queue and back
// depends on mrc_pkg, mrc_in_if, mrc_out_if, mrc_fifo, mrc_front, mrc_back
//
//   port       | role   | carries
//   -----------+--------+-----------------------------------------------
//   in_ch      | sink   | func, sample (signed Q16.16), pass_last
//   out_ch     | source | value (signed 32), last
//   cfg_*      | write  | cfg_we, cfg_index (0 out_min, 1 out_max, 2 out_mode), cfg_data
//
// measure items update the running min/max in the front; only the last of a pass queues work
// scaled convert item: the back sequencer runs two multiplier halves, accumulate,
// offset, truncate, saturate; unscaled convert item: truncate and saturate only
// pass end of measure: the bit-serial divider forms the scale, then the same steps latch the base
// the queue lets the front keep taking samples while the back or output stalls, until it is full
// synchronous active-low reset; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module minmax_rescale_convert #(
  parameter int FRAC_BITS = mrc_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mrc_in_if.sink                         in_ch,
  mrc_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [mrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mrc_pkg::CFG_W-1:0]      cfg_data
);
  import mrc_pkg::*;

  cfg_t cfg_r;
  cmd_t push_data, pop_data;
  logic push, pop, full, empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OUT_MIN:  cfg_r.out_min  <= cfg_data;
        CFG_OUT_MAX:  cfg_r.out_max  <= cfg_data;
        CFG_OUT_MODE: cfg_r.out_mode <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  mrc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (full),
    .q_push (push),
    .q_data (push_data)
  );

  mrc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  mrc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (!empty),
    .cmd       (pop_data),
    .cmd_pop   (pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

@@ sim/minmax_rescale_convert_test.sv @@
// minmax_rescale_convert_test: self-checking testbench for the min/max rescale converter
// depends on mrc_pkg, mrc_in_if, mrc_out_if and the minmax_rescale_convert rtl
// a directed table of items and register writes, then random measure and convert passes
`timescale 1ns / 1ps

module minmax_rescale_convert_test;
  import mrc_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int SETTLE_CYCLES = 4 * (FB + 41);
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 500;
  localparam int SCRIPT_LEN = 34;

  typedef logic signed [127:0] acc_t;
  localparam acc_t GAIN_MAX = (acc_t'(1) <<< (SCALE_W - 1)) - 1;
  localparam acc_t GAIN_MIN = -(acc_t'(1) <<< (SCALE_W - 1));
  localparam acc_t FIX_MAX = (acc_t'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam acc_t FIX_MIN = -(acc_t'(1) <<< (SAMPLE_W - 1));

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
  } pixel_t;

  typedef enum bit {ROW_WRITE, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_W-1:0]      data;
    logic                  func;
    logic [SAMPLE_W-1:0]   sample;
    logic                  pass_last;
    logic                  typed;
    logic [SAMPLE_W-1:0]   value;
  } row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  mrc_in_if  in_ch ();
  mrc_out_if out_ch ();

  minmax_rescale_convert u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state and register copies
  logic signed [SAMPLE_W-1:0] seen_lo = '0;
  logic signed [SAMPLE_W-1:0] seen_hi = '0;
  logic signed [SCALE_W-1:0]  gain = '0;
  logic signed [SCALE_W-1:0]  offset = '0;
  logic                       restart = 1'b1;
  logic signed [CFG_W-1:0]    range_lo = '0;
  logic signed [CFG_W-1:0]    range_hi = '0;
  logic [MODE_W-1:0]          out_type = MODE_BYTE;

  pixel_t expected_pixels[$];
  int     errors = 0;
  int     idle_cycles = 0;
  int     out_hold = 0;
  bit     eager = 1'b0;
  row_t   script [SCRIPT_LEN];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic acc_t div_pow2(acc_t v, int k);
    return v / (acc_t'(1) <<< k);
  endfunction

  function automatic acc_t clamp(acc_t v, acc_t lo, acc_t hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic bit stretch_pixel(input logic func, input logic signed [SAMPLE_W-1:0] px,
                                       input logic pass_last, output pixel_t res);
    acc_t span;
    acc_t acc;
    res = '0;
    if (func == FUNC_MEASURE) begin
      if (restart) begin
        seen_lo = px;
        seen_hi = px;
        restart = 1'b0;
      end else begin
        if (px < seen_lo) seen_lo = px;
        if (px > seen_hi) seen_hi = px;
      end
      if (pass_last) begin
        // flat data stretches over one unit
        span = acc_t'(seen_hi) - acc_t'(seen_lo);
        if (span <= 0) span = acc_t'(1) <<< FB;
        acc = clamp(((acc_t'(range_hi) - acc_t'(range_lo)) <<< FB) / span, GAIN_MIN, GAIN_MAX);
        gain = acc[SCALE_W-1:0];
        acc = (acc_t'(range_lo) <<< FB) - acc_t'(gain) * acc_t'(seen_lo);
        acc = clamp(div_pow2(acc, FB), GAIN_MIN, GAIN_MAX);
        offset = acc[SCALE_W-1:0];
        restart = 1'b1;
      end
      return 1'b0;
    end
    if (range_lo != 0 || range_hi != 0) begin
      acc = acc_t'(px) * acc_t'(gain) + (acc_t'(offset) <<< FB);
      acc = div_pow2(acc, out_type == MODE_FIXED ? FB : 2 * FB);
    end else if (out_type == MODE_FIXED) begin
      acc = acc_t'(px);
    end else begin
      acc = div_pow2(acc_t'(px), FB);
    end
    case (out_type)
      MODE_BYTE: acc = clamp(acc, 0, BYTE_MAX);
      MODE_S16:  acc = clamp(acc, S16_MIN, S16_MAX);
      MODE_U16:  acc = clamp(acc, 0, U16_MAX);
      default:   acc = clamp(acc, FIX_MIN, FIX_MAX);
    endcase
    res.value = acc[SAMPLE_W-1:0];
    res.last = pass_last;
    if (pass_last) restart = 1'b1;
    return 1'b1;
  endfunction

  function automatic logic [CFG_W-1:0] pick_bound();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3, 4:    return $urandom_range(0, 255) << FB;
      5:       return (32'($urandom_range(0, 65535)) - 32'd32768) << FB;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_pixel(logic [SAMPLE_W-1:0] center, int spread);
    case ($urandom_range(0, 15))
      0:       return $urandom;
      1:       return 32'h8000_0000;
      2:       return 32'h7fff_ffff;
      default: return center + ($urandom & ((32'd1 << spread) - 1)) - (32'd1 << (spread - 1));
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      CFG_OUT_MIN:  range_lo = val;
      CFG_OUT_MAX:  range_hi = val;
      CFG_OUT_MODE: out_type = val[MODE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_item(logic func, logic [SAMPLE_W-1:0] px, logic pass_last,
                           logic typed = 1'b0, logic [SAMPLE_W-1:0] typed_value = '0);
    int     gap;
    int     r;
    pixel_t res;
    gap = 0;
    if (!eager) begin
      r = $urandom_range(0, 99);
      gap = r < 60 ? 0 : (r < 90 ? $urandom_range(1, 3) : $urandom_range(8, 30));
    end
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.func = func;
    in_ch.sample = px;
    in_ch.pass_last = pass_last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (stretch_pixel(func, px, pass_last, res)) begin
      if (typed) res.value = typed_value;
      expected_pixels.push_back(res);
    end
  endtask

  // drain results, then give the divider time to finish a pending latch
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin : result_stall
    int r;
    if (out_hold > 0) begin
      out_hold--;
    end else begin
      r = $urandom_range(0, 9);
      out_ch.ready = r < 5;
      out_hold = r < 5 ? $urandom_range(1, 24) :
                 (r < 9 ? $urandom_range(0, 2) : $urandom_range(10, 40));
    end
  end

  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_pixels.size() == 0) begin
        errors++;
        $error("result with none expected: value %h last %b", out_ch.value, out_ch.last);
      end else begin
        want = expected_pixels.pop_front();
        if (out_ch.value !== want.value) begin
          errors++;
          $error("value: expected %h, actual %h", want.value, out_ch.value);
        end
        if (out_ch.last !== want.last) begin
          errors++;
          $error("last: expected %b, actual %b", want.last, out_ch.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $error("no item moved for %0d cycles", STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int                  random_items;
    int                  len;
    int                  shape;
    int                  spread;
    logic [SAMPLE_W-1:0] center;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_OUT_MIN;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_MEASURE;
    in_ch.sample = '0;
    in_ch.pass_last = 1'b0;
    out_ch.ready = 1'b0;
    random_items = 0;

    // kind, index, data, func, sample, pass_last, typed, expected value
    script = '{
      // unscaled conversion after reset, every output type
      '{ROW_ITEM,  CFG_OUT_MIN,  32'h0, FUNC_CONVERT, 32'h0005_8000, 1'b0, 1'b1, 32'd5},
      '{ROW_ITEM,  CFG_OUT_MIN,  32'h0, FUNC_CONVERT, 32'h7fff_ffff, 1'b0, 1'b1, 32'd255},
      '{ROW_ITEM,  CFG_OUT_MIN,  32'h0, FUNC_CONVERT, 32'h8000_0000, 1'b0, 1'b1, 32'd0},
      '{ROW_ITEM,  CFG_OUT_MIN,  32'h0, FUNC_CONVERT, 32'hfffe_8000, 1'b1, 1'b1, 32'd0},
      '{ROW_WRITE, CFG_OUT_MODE, 32'(MODE_S16), FUNC_MEASURE, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM,  CFG_OUT_MIN,  32'h0, FUNC_CONVERT, 32'h7fff_ffff, 1'b0, 1'b1, 32'h0000_7fff},
      '{ROW_ITEM,  CFG_OUT_MIN,  32'h0, FUNC_CONVERT, 32'h8000_0000, 1'b0, 1'b1, 32'hffff_8000},
      '{ROW_ITEM,  CFG_OUT_MIN,  32'h0, FUNC_CONVERT, 32'hfffe_8000, 1'b1, 1'b1, 32'hffff_ffff},
      '{ROW_WRITE, CFG_OUT_MODE, 32'(MODE_U16), FUNC_MEASURE, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM,  CFG_OUT_MIN,  32'h0, FUNC_CONVERT, 32'h7fff_ffff, 1'b0, 1'b1, 32'h0000_7fff},
      '{ROW_ITEM,  CFG_OUT_MIN,  32'h0, FUNC_CONVERT, 32'hffff_0000, 1'b1, 1'b1, 32'd0},
      '{ROW_WRITE, CFG_OUT_MODE, 32'(MODE_FIXED), FUNC_MEASURE, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM,  CFG_OUT_MIN,  32'h0, FUNC_CONVERT, 32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000},
      '{ROW_ITEM,  CFG_OUT_MIN,  32'h0, FUNC_CONVERT, 32'h1234_5678, 1'b1, 1'b1, 32'h1234_5678},
      // scaling on with nothing measured yet
      '{ROW_WRITE, CFG_OUT_MAX,  32'h00ff_0000, FUNC_MEASURE, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM,  CFG_OUT_MIN,  32'h0, FUNC_CONVERT, 32'h0064_0000, 1'b1, 1'b1, 32'd0},
      '{ROW_WRITE, CFG_OUT_MODE, 32'(MODE_BYTE), FUNC_MEASURE, 32'h0, 1'b0, 1'b0, 32'h0},
      // ordinary stretch of 10.0 .. 30.0 onto 0 .. 255
      '{ROW_ITEM,  CFG_OUT_MIN,  32'h0, FUNC_MEASURE, 32'h000a_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM,  CFG_OUT_MIN,  32'h0, FUNC_MEASURE, 32'h001e_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM,  CFG_OUT_MIN,  32'h0, FUNC_MEASURE, 32'h0014_0000, 1'b1, 1'b0, 32'h0},
      '{ROW_ITEM,  CFG_OUT_MIN,  32'h0, FUNC_CONVERT, 32'h000a_0000, 1'b0, 1'b1, 32'd0},
      '{ROW_ITEM,  CFG_OUT_MIN,  32'h0, FUNC_CONVERT, 32'h001e_0000, 1'b0, 1'b1, 32'd255},
      '{ROW_ITEM,  CFG_OUT_MIN,  32'h0, FUNC_CONVERT, 32'h0019_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM,  CFG_OUT_MIN,  32'h0, FUNC_CONVERT, 32'h0028_0000, 1'b0, 1'b1, 32'd255},
      '{ROW_ITEM,  CFG_OUT_MIN,  32'h0, FUNC_CONVERT, 32'h0000_0000, 1'b1, 1'b1, 32'd0},
      // widest output range over a one-lsb input range saturates the gain
      '{ROW_WRITE, CFG_OUT_MIN,  32'h8000_0000, FUNC_MEASURE, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_WRITE, CFG_OUT_MAX,  32'h7fff_ffff, FUNC_MEASURE, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_WRITE, CFG_OUT_MODE, 32'(MODE_FIXED), FUNC_MEASURE, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM,  CFG_OUT_MIN,  32'h0, FUNC_MEASURE, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM,  CFG_OUT_MIN,  32'h0, FUNC_MEASURE, 32'h0000_0001, 1'b1, 1'b0, 32'h0},
      '{ROW_ITEM,  CFG_OUT_MIN,  32'h0, FUNC_CONVERT, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM,  CFG_OUT_MIN,  32'h0, FUNC_CONVERT, 32'h8000_0000, 1'b1, 1'b0, 32'h0},
      // flat data, single-sample pass
      '{ROW_ITEM,  CFG_OUT_MIN,  32'h0, FUNC_MEASURE, 32'h0005_0000, 1'b1, 1'b0, 32'h0},
      '{ROW_ITEM,  CFG_OUT_MIN,  32'h0, FUNC_CONVERT, 32'h0005_0000, 1'b1, 1'b0, 32'h0}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        settle();
        write_reg(script[i].index, script[i].data);
      end else begin
        send_item(script[i].func, script[i].sample, script[i].pass_last,
                  script[i].typed, script[i].value);
      end
    end

    while (random_items < RANDOM_ITEMS) begin
      settle();
      eager = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) begin
        write_reg(CFG_OUT_MIN, '0);
        write_reg(CFG_OUT_MAX, '0);
      end else begin
        if ($urandom_range(0, 2) != 0) write_reg(CFG_OUT_MIN, pick_bound());
        if ($urandom_range(0, 2) != 0) write_reg(CFG_OUT_MAX, pick_bound());
      end
      if ($urandom_range(0, 2) != 0) write_reg(CFG_OUT_MODE, CFG_W'($urandom_range(0, 3)));
      center = $urandom;
      if ($urandom_range(0, 1) == 0) center = $signed(center) >>> $urandom_range(4, 14);
      spread = $urandom_range(1, 26);
      shape = $urandom_range(0, 9);
      if (shape < 7) begin
        // well-formed measure pass then convert pass
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++)
          send_item(FUNC_MEASURE, pick_pixel(center, spread), k == len - 1);
        random_items += len;
        if (shape == 0) begin
          // registers change between the passes
          settle();
          write_reg(CFG_OUT_MODE, CFG_W'($urandom_range(0, 3)));
          if ($urandom_range(0, 1) == 0) write_reg(CFG_OUT_MAX, pick_bound());
        end
        len = $urandom_range(1, 16);
        for (int k = 0; k < len; k++)
          send_item(FUNC_CONVERT, pick_pixel(center, spread), k == len - 1);
        random_items += len;
      end else if (shape < 9) begin
        // measure pass cut short, convert pass with or without an end
        len = shape == 7 ? 0 : $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
          send_item(FUNC_MEASURE, pick_pixel(center, spread), 1'b0);
        random_items += len;
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++)
          send_item(FUNC_CONVERT, pick_pixel(center, spread),
                    k == len - 1 && $urandom_range(0, 1) == 0);
        random_items += len;
      end else begin
        len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++)
          send_item(logic'($urandom_range(0, 1)), pick_pixel(center, spread),
                    $urandom_range(0, 3) == 0);
        random_items += len;
      end
    end

    settle();
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
